/* sv/thick_line_quad_expander_top_assert.svh */
// Assertion macros used by the thick line quad expander output stage.
// The including module must provide clk and rst_n.
`ifndef THICK_LINE_QUAD_EXPANDER_TOP_ASSERT_SVH
`define THICK_LINE_QUAD_EXPANDER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLQE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlqe: same-cycle check failed");
`define TLQE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlqe: next-cycle check failed");
`else
`define TLQE_ASSERT_IMP(lbl, ante, cons)
`define TLQE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/tlqe_pkg.sv */
// Types and constants of the thick line quad expander.
// No dependencies.
`default_nettype none
package tlqe_pkg;
  localparam int CW         = 16;
  localparam int OUT_W      = 24;
  localparam int OUT_MAX    = 8388607;
  localparam int OUT_MIN    = -8388608;
  localparam int LEN_W      = 25;
  localparam int RAD_W      = 50;
  localparam int REM_W      = 28;
  localparam int SUMSQ_W    = 34;
  localparam int NUM_W      = 32;
  localparam int DIV_W      = 42;
  localparam int Q_W        = 16;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 16;

  typedef enum logic [1:0] {
    CORNER_START_POS = 2'd0,
    CORNER_START_NEG = 2'd1,
    CORNER_END_POS   = 2'd2,
    CORNER_END_NEG   = 2'd3
  } corner_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 dx_neg;
    logic                 dy_pos;
    logic                 degen;
    logic [NUM_W-1:0]     numx;
    logic [NUM_W-1:0]     numy;
  } seg_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem_x;
    logic [DIV_W-1:0] rem_y;
    logic [DIV_W-1:0] dvs;
    logic [Q_W-1:0]   q_x;
    logic [Q_W-1:0]   q_y;
  } div_t;
endpackage
`default_nettype wire

/* sv/thick_line_quad_expander_top.sv */
// Thick line quad expander top level: front stages, square root and divider
// cell chains, output stage. Depends on tlqe_pkg, the cells and tlqe_emit.
//
//   channel | direction | ports
//   in_     | request   | in_valid/in_ready, start_x, start_y, end_x, end_y, half_width
//   out_    | result    | out_valid/out_ready, vertex_x, vertex_y, corner, degenerate, last
//
// A segment runs through 3 front stages, 25 square root cells, 1 setup stage
// and 16 divider cells before its first corner appears.
// Each segment then occupies the output stage until its four corners are taken,
// one per handshake; the next segment can load as the last corner is taken.
// The whole chain advances together; it stalls only while the output stage
// is busy and the last divider cell holds a finished segment.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
module thick_line_quad_expander_top import tlqe_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CW-1:0]    in_start_x,
  input  logic signed [CW-1:0]    in_start_y,
  input  logic signed [CW-1:0]    in_end_x,
  input  logic signed [CW-1:0]    in_end_y,
  input  logic [CW-1:0]           in_half_width,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_vertex_x,
  output logic signed [OUT_W-1:0] out_vertex_y,
  output logic [1:0]              out_corner,
  output logic                    out_degenerate,
  output logic                    out_last
);
  logic en, em_ready;

  logic                 a_v_r, b_v_r, c_v_r, p_v_r;
  seg_t                 a_seg_r, b_seg_r, c_seg_r, p_seg_r;
  seg_t                 a_seg_nxt, b_seg_nxt, c_seg_nxt;
  logic signed [CW:0]   a_dx_r, a_dy_r;
  logic [CW-1:0]        a_w_r, b_w_r, b_adx_r, b_ady_r;
  logic [SUMSQ_W-1:0]   b_sqx_r, b_sqy_r, c_s_r;
  logic signed [CW:0]   dx_nxt, dy_nxt, adx_full, ady_full;
  logic [2*CW+1:0]      sqx_full, sqy_full;
  div_t                 p_dv_r;

  logic  sq_v   [SQRT_STEPS+1];
  sqrt_t sq_d   [SQRT_STEPS+1];
  seg_t  sq_seg [SQRT_STEPS+1];
  logic  dv_v   [DIV_STEPS+1];
  div_t  dv_d   [DIV_STEPS+1];
  seg_t  dv_seg [DIV_STEPS+1];

  assign en       = em_ready || !dv_v[DIV_STEPS];
  assign in_ready = en;

  always_comb begin
    dx_nxt   = (CW+1)'(in_end_x) - (CW+1)'(in_start_x);
    dy_nxt   = (CW+1)'(in_end_y) - (CW+1)'(in_start_y);
    adx_full = a_dx_r[CW] ? -a_dx_r : a_dx_r;
    ady_full = a_dy_r[CW] ? -a_dy_r : a_dy_r;
    sqx_full = (2*CW+2)'(a_dx_r * a_dx_r);
    sqy_full = (2*CW+2)'(a_dy_r * a_dy_r);
    // Stage A: coordinates and the zero-length test.
    a_seg_nxt       = '0;
    a_seg_nxt.sx    = in_start_x;
    a_seg_nxt.sy    = in_start_y;
    a_seg_nxt.ex    = in_end_x;
    a_seg_nxt.ey    = in_end_y;
    a_seg_nxt.degen = (in_start_x == in_end_x) && (in_start_y == in_end_y);
    // Stage B: signs of the perpendicular.
    b_seg_nxt        = a_seg_r;
    b_seg_nxt.dx_neg = a_dx_r[CW];
    b_seg_nxt.dy_pos = !a_dy_r[CW] && (a_dy_r != '0);
    // Stage C: the unscaled numerators.
    c_seg_nxt      = b_seg_r;
    c_seg_nxt.numx = b_ady_r * b_w_r;
    c_seg_nxt.numy = b_adx_r * b_w_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      p_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      p_v_r <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage A: differences and the zero-length test.
      a_seg_r <= a_seg_nxt;
      a_dx_r  <= dx_nxt;
      a_dy_r  <= dy_nxt;
      a_w_r   <= in_half_width;
      // Stage B: squares and magnitudes.
      b_seg_r <= b_seg_nxt;
      b_sqx_r <= sqx_full[SUMSQ_W-1:0];
      b_sqy_r <= sqy_full[SUMSQ_W-1:0];
      b_adx_r <= adx_full[CW-1:0];
      b_ady_r <= ady_full[CW-1:0];
      b_w_r   <= a_w_r;
      // Stage C: squared length and the unscaled numerators.
      c_seg_r <= c_seg_nxt;
      c_s_r   <= b_sqx_r + b_sqy_r;
      // Setup: rounding term folded into the dividend, divisor aligned.
      p_seg_r      <= sq_seg[SQRT_STEPS];
      p_dv_r.rem_x <= {1'b0, sq_seg[SQRT_STEPS].numx, 9'b0}
                      + DIV_W'(sq_d[SQRT_STEPS].root);
      p_dv_r.rem_y <= {1'b0, sq_seg[SQRT_STEPS].numy, 9'b0}
                      + DIV_W'(sq_d[SQRT_STEPS].root);
      p_dv_r.dvs   <= {1'b0, sq_d[SQRT_STEPS].root, 16'b0};
      p_dv_r.q_x   <= '0;
      p_dv_r.q_y   <= '0;
    end
  end

  assign sq_v[0]   = c_v_r;
  assign sq_d[0]   = '{rad: {c_s_r, 16'b0}, rem: '0, root: '0};
  assign sq_seg[0] = c_seg_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    tlqe_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_v   (sq_v[i]),
      .in_sq  (sq_d[i]),
      .in_seg (sq_seg[i]),
      .out_v  (sq_v[i+1]),
      .out_sq (sq_d[i+1]),
      .out_seg(sq_seg[i+1])
    );
  end

  assign dv_v[0]   = p_v_r;
  assign dv_d[0]   = p_dv_r;
  assign dv_seg[0] = p_seg_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tlqe_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_v   (dv_v[j]),
      .in_dv  (dv_d[j]),
      .in_seg (dv_seg[j]),
      .out_v  (dv_v[j+1]),
      .out_dv (dv_d[j+1]),
      .out_seg(dv_seg[j+1])
    );
  end

  tlqe_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld_v          (dv_v[DIV_STEPS]),
    .ld_seg        (dv_seg[DIV_STEPS]),
    .ld_qx         (dv_d[DIV_STEPS].q_x),
    .ld_qy         (dv_d[DIV_STEPS].q_y),
    .ld_ready      (em_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_vertex_x  (out_vertex_x),
    .out_vertex_y  (out_vertex_y),
    .out_corner    (out_corner),
    .out_degenerate(out_degenerate),
    .out_last      (out_last)
  );
endmodule
`default_nettype wire

/* sv/tlqe_sqrt_cell.sv */
// One digit step of the square root chain: two radicand bits in, one root bit out.
// Depends on tlqe_pkg.
`default_nettype none
module tlqe_sqrt_cell import tlqe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_v,
  input  sqrt_t in_sq,
  input  seg_t  in_seg,
  output logic  out_v,
  output sqrt_t out_sq,
  output seg_t  out_seg
);
  logic  v_r;
  sqrt_t sq_r, sq_nxt;
  seg_t  seg_r;
  logic [REM_W-1:0] rem_sh, trial;

  always_comb begin
    rem_sh = {in_sq.rem[REM_W-3:0], in_sq.rad[RAD_W-1 -: 2]};
    trial  = {{(REM_W-LEN_W-2){1'b0}}, in_sq.root, 2'b01};
    sq_nxt.rad = {in_sq.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_nxt.rem  = rem_sh - trial;
      sq_nxt.root = {in_sq.root[LEN_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_sh;
      sq_nxt.root = {in_sq.root[LEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_nxt;
      seg_r <= in_seg;
    end
  end

  assign out_v   = v_r;
  assign out_sq  = sq_r;
  assign out_seg = seg_r;
endmodule
`default_nettype wire

/* sv/tlqe_div_cell.sv */
// One restoring division step for both offset components at once.
// Depends on tlqe_pkg.
`default_nettype none
module tlqe_div_cell import tlqe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  div_t in_dv,
  input  seg_t in_seg,
  output logic out_v,
  output div_t out_dv,
  output seg_t out_seg
);
  logic v_r;
  div_t dv_r, dv_nxt;
  seg_t seg_r;
  logic ge_x, ge_y;

  always_comb begin
    ge_x = in_dv.rem_x >= in_dv.dvs;
    ge_y = in_dv.rem_y >= in_dv.dvs;
    dv_nxt.rem_x = ge_x ? in_dv.rem_x - in_dv.dvs : in_dv.rem_x;
    dv_nxt.rem_y = ge_y ? in_dv.rem_y - in_dv.dvs : in_dv.rem_y;
    dv_nxt.q_x   = {in_dv.q_x[Q_W-2:0], ge_x};
    dv_nxt.q_y   = {in_dv.q_y[Q_W-2:0], ge_y};
    dv_nxt.dvs   = in_dv.dvs >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r  <= dv_nxt;
      seg_r <= in_seg;
    end
  end

  assign out_v   = v_r;
  assign out_dv  = dv_r;
  assign out_seg = seg_r;
endmodule
`default_nettype wire

/* sv/tlqe_emit.sv */
// Output stage: holds one segment and presents its four corners in turn.
// Depends on tlqe_pkg and the assertion macro header.
`default_nettype none
`include "thick_line_quad_expander_top_assert.svh"
module tlqe_emit import tlqe_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ld_v,
  input  seg_t                    ld_seg,
  input  logic [Q_W-1:0]          ld_qx,
  input  logic [Q_W-1:0]          ld_qy,
  output logic                    ld_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_vertex_x,
  output logic signed [OUT_W-1:0] out_vertex_y,
  output logic [1:0]              out_corner,
  output logic                    out_degenerate,
  output logic                    out_last
);
  localparam int SW = (CW + FRAC_BITS + 2 > OUT_W + 2) ? CW + FRAC_BITS + 2 : OUT_W + 2;
  localparam logic signed [SW-1:0] VMAX = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] VMIN = SW'(OUT_MIN);

  logic                 v_r;
  corner_t              k_r;
  seg_t                 seg_r;
  logic signed [Q_W:0]  ox_r, oy_r, ox_nxt, oy_nxt;
  logic                 at_end, minus, take;
  logic signed [CW-1:0] bx, by;
  logic signed [SW-1:0] base_x, base_y, ofs_x, ofs_y, sum_x, sum_y;

  // Offsets take their sign from the perpendicular (-dy, dx).
  always_comb begin
    ox_nxt = '0;
    oy_nxt = '0;
    if (!ld_seg.degen) begin
      ox_nxt = ld_seg.dy_pos ? -$signed({1'b0, ld_qx}) : $signed({1'b0, ld_qx});
      oy_nxt = ld_seg.dx_neg ? -$signed({1'b0, ld_qy}) : $signed({1'b0, ld_qy});
    end
  end

  always_comb begin
    at_end = (k_r == CORNER_END_POS) || (k_r == CORNER_END_NEG);
    minus  = (k_r == CORNER_START_NEG) || (k_r == CORNER_END_NEG);
    bx     = at_end ? seg_r.ex : seg_r.sx;
    by     = at_end ? seg_r.ey : seg_r.sy;
    base_x = SW'(bx) <<< FRAC_BITS;
    base_y = SW'(by) <<< FRAC_BITS;
    ofs_x  = SW'(ox_r);
    ofs_y  = SW'(oy_r);
    sum_x  = minus ? base_x - ofs_x : base_x + ofs_x;
    sum_y  = minus ? base_y - ofs_y : base_y + ofs_y;
    if (sum_x > VMAX) begin
      out_vertex_x = OUT_W'(VMAX);
    end else if (sum_x < VMIN) begin
      out_vertex_x = OUT_W'(VMIN);
    end else begin
      out_vertex_x = sum_x[OUT_W-1:0];
    end
    if (sum_y > VMAX) begin
      out_vertex_y = OUT_W'(VMAX);
    end else if (sum_y < VMIN) begin
      out_vertex_y = OUT_W'(VMIN);
    end else begin
      out_vertex_y = sum_y[OUT_W-1:0];
    end
  end

  assign take           = v_r && out_ready;
  assign ld_ready       = !v_r || (out_ready && k_r == CORNER_END_NEG);
  assign out_valid      = v_r;
  assign out_corner     = k_r;
  assign out_degenerate = seg_r.degen;
  assign out_last       = (k_r == CORNER_END_NEG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      k_r <= CORNER_START_POS;
    end else if (ld_v && ld_ready) begin
      v_r <= 1'b1;
      k_r <= CORNER_START_POS;
    end else if (take) begin
      if (k_r == CORNER_END_NEG) begin
        v_r <= 1'b0;
      end
      k_r <= corner_t'(k_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_v && ld_ready) begin
      seg_r <= ld_seg;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
    end
  end

  `TLQE_ASSERT_NXT(a_hold_on_stall, v_r && !out_ready, v_r && $stable(k_r))
  `TLQE_ASSERT_NXT(a_corner_steps, take && k_r != CORNER_END_NEG,
                   v_r && k_r == corner_t'($past(k_r) + 2'd1))
  `TLQE_ASSERT_IMP(a_degen_zero_ofs, v_r && seg_r.degen, ox_r == '0 && oy_r == '0)
endmodule
`default_nettype wire
